// ===== rtl/mauq_pkg.sv =====
// Package for the multichannel access-unit ring queue.
// Sizes, beat layouts, action/status/register codes, controller command type
// and the backward-jump compare. No dependencies.
package mauq_pkg;

  localparam int NUM_CHANNELS = 4;    // 1..8
  localparam int MAX_SLOTS    = 256;  // 2..4096

  localparam int CH_W     = 3;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 3;
  localparam int ADDR32_W = 32;
  localparam int CNT_W    = 8;
  localparam int QN_W     = 9;
  localparam int EN_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int IDX_W    = $clog2(MAX_SLOTS);
  localparam int CAP_W    = $clog2(MAX_SLOTS + 1);
  localparam int MEM_DEPTH = NUM_CHANNELS * MAX_SLOTS;
  localparam int MEM_AW    = CH_IDX_W + IDX_W;
  localparam int CAP_RST   = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;

  // Beat layouts
  localparam int IN_USER_W  = ACT_W + CH_W;        // action, channel
  localparam int IN_DATA_W  = 4 * ADDR32_W;        // start, end, size, reset addr
  localparam int OUT_USER_W = STAT_W;              // status
  localparam int OUT_RAW_W  = 4 * ADDR32_W + 2 * CNT_W + 2;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Action codes; 5..7 behave as a count query
  localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RESET = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_CH = 3'd1;
  localparam logic [STAT_W-1:0] ST_CLOSED = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_NODES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPB_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CH_ENABLE   = 2'd2;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic accept;  // capture item, launch slot read
    logic exec;    // resolve item, update state, load result
  } cmd_t;

  // prev - cur < floor(8*cpb/10)  <=>  5*(prev - cur + 1) <= 4*cpb
  function automatic logic back_jump(input logic [31:0] prev, input logic [31:0] cur,
                                     input logic [31:0] cpb);
    logic [32:0] d1;
    logic [34:0] lhs;
    logic [34:0] rhs;
    d1  = {1'b0, prev - cur} + 33'd1;
    lhs = {d1, 2'b00} + {2'b00, d1};
    rhs = {1'b0, cpb, 2'b00};
    return (prev != 32'd0) && (prev > cur) && (lhs <= rhs);
  endfunction

endpackage

// ===== rtl/mauq_ctrl.sv =====
// Controller state machine for the ring queue: input/result handshakes.
// Depends on mauq_pkg.
module mauq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output mauq_pkg::cmd_t cmd
);
  import mauq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // result register can be loaded when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      S_EXEC: cmd.exec = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/mauq_dp.sv =====
// Datapath of the ring queue: config registers, per-channel pointers,
// descriptor slot memory and result register. Depends on mauq_pkg.
module mauq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mauq_pkg::cmd_t                      cmd,
  input  logic                                cfg_we,
  input  logic [mauq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mauq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [mauq_pkg::IN_USER_W-1:0]      in_tuser,
  input  logic [mauq_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic [mauq_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic [mauq_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import mauq_pkg::*;

  // configuration
  logic [CAP_W-1:0] cap_r;
  logic [31:0]      cpb_r;
  logic [EN_W-1:0]  en_r;

  // per-channel state
  logic [IDX_W-1:0] w_idx_r   [NUM_CHANNELS];
  logic [IDX_W-1:0] r_idx_r   [NUM_CHANNELS];
  logic [31:0]      cwa_r     [NUM_CHANNELS];
  logic [31:0]      push_st_r [NUM_CHANNELS];
  logic [31:0]      push_en_r [NUM_CHANNELS];
  logic [31:0]      pop_st_r  [NUM_CHANNELS];
  logic [31:0]      pop_en_r  [NUM_CHANNELS];

  // descriptor slots: {size, end, start}
  logic [3*32-1:0]  mem [MEM_DEPTH];
  logic [3*32-1:0]  rd_q;

  // item captured at accept
  logic [ACT_W-1:0]    act_r;
  logic [CH_IDX_W-1:0] ch_r;
  logic                bad_r, open_r;
  logic [31:0]         a_st_r, a_en_r, a_sz_r, rst_addr_r;
  logic [IDX_W-1:0]    w_r, r_r;
  logic [31:0]         cwa_c_r, pst_c_r, pen_c_r, ost_c_r, oen_c_r;

  // result register
  logic [OUT_USER_W-1:0] ostat_r;
  logic [OUT_DATA_W-1:0] odata_r;

  logic [CH_W-1:0]     in_ch;
  logic [CH_IDX_W-1:0] in_ci;
  logic                in_bad, in_open;

  assign in_ch   = in_tuser[ACT_W +: CH_W];
  assign in_ci   = in_ch[CH_IDX_W-1:0];
  assign in_bad  = 32'(in_ch) >= 32'(NUM_CHANNELS);
  assign in_open = (32'(in_ch) < 32'(EN_W)) ? en_r[in_ch[$clog2(EN_W)-1:0]] : 1'b0;

  // --- exec-cycle logic ---
  logic [STAT_W-1:0] stat;
  logic [31:0]       o_st, o_en, o_sz, o_cwa;
  logic              sj, ej, we;
  logic [IDX_W-1:0]  nw, nr;
  logic [31:0]       ncwa, npst, npen, nost, noen;
  logic [CAP_W-1:0]  w_inc, r_inc, adv_w, adv_r, used_old, used_new, free_new;
  logic [CNT_W-1:0]  used_o, free_o;

  assign w_inc = CAP_W'(w_r) + CAP_W'(1);
  assign r_inc = CAP_W'(r_r) + CAP_W'(1);
  assign adv_w = (w_inc >= cap_r) ? '0 : w_inc;
  assign adv_r = (r_inc >= cap_r) ? '0 : r_inc;
  assign used_old = (w_r >= r_r) ? CAP_W'(w_r) - CAP_W'(r_r)
                                 : CAP_W'(w_r) + cap_r - CAP_W'(r_r);

  always_comb begin
    stat = ST_OK;
    o_st = '0;
    o_en = '0;
    o_sz = '0;
    sj   = 1'b0;
    ej   = 1'b0;
    we   = 1'b0;
    nw   = w_r;
    nr   = r_r;
    ncwa = cwa_c_r;
    npst = pst_c_r;
    npen = pen_c_r;
    nost = ost_c_r;
    noen = oen_c_r;
    if (bad_r) begin
      stat = ST_BAD_CH;
    end else if (act_r == ACT_RESET) begin
      nw   = '0;
      nr   = '0;
      ncwa = rst_addr_r;
      npst = '0;
      npen = '0;
      nost = '0;
      noen = '0;
    end else if (!open_r) begin
      stat = ST_CLOSED;
    end else begin
      case (act_r)
        ACT_PUSH: begin
          if (adv_w == CAP_W'(r_r)) begin
            stat = ST_FULL;
          end else begin
            we   = 1'b1;
            nw   = adv_w[IDX_W-1:0];
            ncwa = a_en_r;
            sj   = back_jump(pst_c_r, a_st_r, cpb_r);
            ej   = back_jump(pen_c_r, a_en_r, cpb_r);
            npst = a_st_r;
            npen = a_en_r;
          end
        end
        ACT_POP, ACT_PEEK: begin
          if (used_old == '0) begin
            stat = ST_EMPTY;
          end else begin
            o_st = rd_q[31:0];
            o_en = rd_q[63:32];
            o_sz = rd_q[95:64];
            if (act_r == ACT_POP) begin
              nr   = adv_r[IDX_W-1:0];
              sj   = back_jump(ost_c_r, o_st, cpb_r);
              ej   = back_jump(oen_c_r, o_en, cpb_r);
              nost = o_st;
              noen = o_en;
            end
          end
        end
        default: ;  // query and unused codes
      endcase
    end
  end

  assign used_new = (nw >= nr) ? CAP_W'(nw) - CAP_W'(nr)
                               : CAP_W'(nw) + cap_r - CAP_W'(nr);
  assign free_new = cap_r - CAP_W'(1) - used_new;
  assign used_o   = (stat == ST_CLOSED || stat == ST_BAD_CH) ? '0 : CNT_W'(used_new);
  assign free_o   = (stat == ST_CLOSED || stat == ST_BAD_CH) ? '0 : CNT_W'(free_new);
  assign o_cwa    = bad_r ? '0 : ncwa;

  // slot memory: write on push, registered read at accept
  always_ff @(posedge clk) begin
    if (cmd.exec && we) mem[{ch_r, w_r}] <= {a_sz_r, a_en_r, a_st_r};
    if (cmd.accept) rd_q <= mem[{in_ci, r_idx_r[in_ci]}];
  end

  // capture item and its channel state
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r      <= in_tuser[ACT_W-1:0];
      ch_r       <= in_ci;
      bad_r      <= in_bad;
      open_r     <= in_open;
      a_st_r     <= in_tdata[31:0];
      a_en_r     <= in_tdata[63:32];
      a_sz_r     <= in_tdata[95:64];
      rst_addr_r <= in_tdata[127:96];
      w_r        <= w_idx_r[in_ci];
      r_r        <= r_idx_r[in_ci];
      cwa_c_r    <= cwa_r[in_ci];
      pst_c_r    <= push_st_r[in_ci];
      pen_c_r    <= push_en_r[in_ci];
      ost_c_r    <= pop_st_r[in_ci];
      oen_c_r    <= pop_en_r[in_ci];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ostat_r <= stat;
      odata_r <= OUT_DATA_W'({ej, sj, o_cwa, free_o, used_o, o_sz, o_en, o_st});
    end
  end

  assign out_tuser = ostat_r;
  assign out_tdata = odata_r;

  // config and per-channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(CAP_RST);
      cpb_r <= '0;
      en_r  <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        w_idx_r[c]   <= '0;
        r_idx_r[c]   <= '0;
        cwa_r[c]     <= '0;
        push_st_r[c] <= '0;
        push_en_r[c] <= '0;
        pop_st_r[c]  <= '0;
        pop_en_r[c]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUEUE_NODES: begin
            if (cfg_data[QN_W-1:0] < QN_W'(2)) cap_r <= CAP_W'(2);
            else if (32'(cfg_data[QN_W-1:0]) > 32'(MAX_SLOTS)) cap_r <= CAP_W'(MAX_SLOTS);
            else cap_r <= CAP_W'(cfg_data[QN_W-1:0]);
            for (int c = 0; c < NUM_CHANNELS; c++) begin
              w_idx_r[c] <= '0;
              r_idx_r[c] <= '0;
            end
          end
          CFG_CPB_SIZE:  cpb_r <= cfg_data;
          CFG_CH_ENABLE: en_r  <= cfg_data[EN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.exec && !bad_r) begin
        w_idx_r[ch_r]   <= nw;
        r_idx_r[ch_r]   <= nr;
        cwa_r[ch_r]     <= ncwa;
        push_st_r[ch_r] <= npst;
        push_en_r[ch_r] <= npen;
        pop_st_r[ch_r]  <= nost;
        pop_en_r[ch_r]  <= noen;
      end
    end
  end

endmodule

// ===== rtl/multichannel_access_unit_ring_queue.sv =====
// Top level of the multichannel access-unit ring queue.
// Instantiates mauq_ctrl and mauq_dp; depends on mauq_pkg.
//
// Per-channel circular queues of access-unit descriptors (start, end, size)
// with push, pop, peek, channel reset and count query. Each item has an
// accept step and an exec step: in the accept cycle the channel pointers
// are sampled and the slot memory (one read port, registered) is read at
// the channel's read index; in the exec step the item is resolved, pointers
// and the slot are written back and the result register is loaded. A new
// beat is taken while a result still waits in the output register, but none
// during an exec step; a result held by out_tready low stalls only that step.
// Each ring keeps one slot unused; capacity is queue_nodes clamped to 2..256.
// Push/pop flag a backward jump when an address drops below the previous
// nonzero one of its kind by less than floor(8*cpb_size/10). The slot store
// has no reset or clearing pass; pointers and previous addresses reset to 0.
// Config writes (cfg_ready always high) are meant for idle periods only;
// writing queue_nodes empties every ring.
module multichannel_access_unit_ring_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  // input beats
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mauq_pkg::IN_USER_W-1:0]      in_tuser,   // action[2:0], channel[5:3]
  input  logic [mauq_pkg::IN_DATA_W-1:0]      in_tdata,   // au_start_addr, au_end_addr,
                                                          // au_size, reset_write_addr
  // result beats
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mauq_pkg::OUT_USER_W-1:0]     out_tuser,  // status[2:0]
  output logic [mauq_pkg::OUT_DATA_W-1:0]     out_tdata,  // out_start_addr, out_end_addr,
                                                          // out_size, used_count,
                                                          // free_count, cpb_write_addr,
                                                          // start_back_jump,
                                                          // end_back_jump, zero pad
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mauq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mauq_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mauq_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  mauq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mauq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

endmodule

// ===== rtl/mauq_chk.sv =====
// Port-level checker for the ring queue, bound to the top level.
// Depends on mauq_pkg.
module mauq_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [mauq_pkg::OUT_USER_W-1:0]     out_tuser,
  input logic [mauq_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import mauq_pkg::*;

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted during item processing");

  // every accepted item yields a result beat after its exec step unless output stalls
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (!out_tvalid || out_tready) |=> ##1 out_tvalid)
    else $error("missing result beat");

  // bad channel result carries nothing
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_BAD_CH |-> out_tdata == '0)
    else $error("bad channel result not zero");

  // closed channel reports zero counts and no flags
  a_closed_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_CLOSED |-> out_tdata[111:96] == '0 && out_tdata[145:144] == '0)
    else $error("closed channel result has counts or flags");

endmodule

bind multichannel_access_unit_ring_queue mauq_chk u_mauq_chk (.*);

// ===== dv/mauq_checker.sv =====
// Checker for the multichannel access-unit ring queue: watches the input, result and
// configuration channels, predicts every result beat and compares it field by field.
// Depends on mauq_pkg.
module mauq_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [mauq_pkg::IN_USER_W-1:0]     in_tuser,
  input  logic [mauq_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [mauq_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic [mauq_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [mauq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mauq_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int unsigned                        fail_count,
  output int unsigned                        outstanding
);
  import mauq_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [31:0]       start_addr;
    logic [31:0]       end_addr;
    logic [31:0]       au_size;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free;
    logic [31:0]       cpb_wr_addr;
    logic              start_jump;
    logic              end_jump;
  } au_result_t;

  // shadow of the block's registers and rings
  logic [QN_W-1:0] qnodes;
  logic [31:0]     cpb;
  logic [EN_W-1:0] ch_open;

  logic [31:0] slot_start [NUM_CHANNELS][MAX_SLOTS];
  logic [31:0] slot_end   [NUM_CHANNELS][MAX_SLOTS];
  logic [31:0] slot_size  [NUM_CHANNELS][MAX_SLOTS];

  int unsigned wr_idx [NUM_CHANNELS];
  int unsigned rd_idx [NUM_CHANNELS];
  logic [31:0] coded_wa        [NUM_CHANNELS];
  logic [31:0] push_start_prev [NUM_CHANNELS];
  logic [31:0] push_end_prev   [NUM_CHANNELS];
  logic [31:0] pop_start_prev  [NUM_CHANNELS];
  logic [31:0] pop_end_prev    [NUM_CHANNELS];

  au_result_t awaited_results [$];
  au_result_t want;
  au_result_t got;

  function automatic int unsigned ring_cap();
    int unsigned c;
    c = qnodes;
    if (c < 2) c = 2;
    if (c > MAX_SLOTS) c = MAX_SLOTS;
    return c;
  endfunction

  function automatic int unsigned next_slot(input int unsigned i, input int unsigned cap);
    return (i + 1 >= cap) ? 0 : i + 1;
  endfunction

  function automatic int unsigned occupancy(input int unsigned c, input int unsigned cap);
    return (wr_idx[c] >= rd_idx[c]) ? wr_idx[c] - rd_idx[c] : wr_idx[c] + cap - rd_idx[c];
  endfunction

  // drop below a nonzero previous address by less than 8/10 of the buffer size
  function automatic logic jumped_back(input logic [31:0] prev, input logic [31:0] cur);
    logic [63:0] limit;
    limit = ({32'd0, cpb} * 64'd8) / 64'd10;
    return (prev != 32'd0) && (prev > cur) && ({32'd0, prev - cur} < limit);
  endfunction

  function automatic au_result_t resolve_access(input logic [ACT_W-1:0] act,
                                                input logic [CH_W-1:0]  ch,
                                                input logic [31:0]      s_addr,
                                                input logic [31:0]      e_addr,
                                                input logic [31:0]      au_sz,
                                                input logic [31:0]      load_addr);
    au_result_t  r;
    int unsigned cap;
    int unsigned c;
    int unsigned nxt;
    int unsigned fill;
    logic        open;
    r = '0;
    if (ch >= NUM_CHANNELS) begin
      r.status = ST_BAD_CH;
      return r;
    end
    cap  = ring_cap();
    c    = ch;
    open = (c < EN_W) ? ch_open[c] : 1'b0;
    if (act == ACT_RESET) begin
      wr_idx[c]          = 0;
      rd_idx[c]          = 0;
      coded_wa[c]        = load_addr;
      push_start_prev[c] = '0;
      push_end_prev[c]   = '0;
      pop_start_prev[c]  = '0;
      pop_end_prev[c]    = '0;
    end else if (!open) begin
      r.status = ST_CLOSED;
    end else if (act == ACT_PUSH) begin
      nxt = next_slot(wr_idx[c], cap);
      if (nxt == rd_idx[c]) begin
        r.status = ST_FULL;
      end else begin
        slot_start[c][wr_idx[c]] = s_addr;
        slot_end[c][wr_idx[c]]   = e_addr;
        slot_size[c][wr_idx[c]]  = au_sz;
        wr_idx[c]          = nxt;
        coded_wa[c]        = e_addr;
        r.start_jump       = jumped_back(push_start_prev[c], s_addr);
        r.end_jump         = jumped_back(push_end_prev[c], e_addr);
        push_start_prev[c] = s_addr;
        push_end_prev[c]   = e_addr;
      end
    end else if (act == ACT_POP || act == ACT_PEEK) begin
      if (occupancy(c, cap) == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.start_addr = slot_start[c][rd_idx[c]];
        r.end_addr   = slot_end[c][rd_idx[c]];
        r.au_size    = slot_size[c][rd_idx[c]];
        if (act == ACT_POP) begin
          rd_idx[c]         = next_slot(rd_idx[c], cap);
          r.start_jump      = jumped_back(pop_start_prev[c], r.start_addr);
          r.end_jump        = jumped_back(pop_end_prev[c], r.end_addr);
          pop_start_prev[c] = r.start_addr;
          pop_end_prev[c]   = r.end_addr;
        end
      end
    end
    // anything else (query and spare codes) only reports counts
    if (r.status != ST_CLOSED) begin
      fill   = occupancy(c, cap);
      r.used = fill[CNT_W-1:0];
      fill   = cap - 1 - fill;
      r.free = fill[CNT_W-1:0];
    end
    r.cpb_wr_addr = coded_wa[c];
    return r;
  endfunction

  function automatic void check_field(input string label, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch, expected %h got %h", $time, label, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      qnodes     = 9'd256;
      cpb        = '0;
      ch_open    = '0;
      fail_count = 0;
      awaited_results.delete();
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        wr_idx[c]          = 0;
        rd_idx[c]          = 0;
        coded_wa[c]        = '0;
        push_start_prev[c] = '0;
        push_end_prev[c]   = '0;
        pop_start_prev[c]  = '0;
        pop_end_prev[c]    = '0;
      end
    end else begin
      // result side first: a beat leaving now belongs to an earlier access
      if (out_tvalid && out_tready) begin
        got.status      = out_tuser;
        got.start_addr  = out_tdata[31:0];
        got.end_addr    = out_tdata[63:32];
        got.au_size     = out_tdata[95:64];
        got.used        = out_tdata[103:96];
        got.free        = out_tdata[111:104];
        got.cpb_wr_addr = out_tdata[143:112];
        got.start_jump  = out_tdata[144];
        got.end_jump    = out_tdata[145];
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with no access pending, status %0d", $time, got.status);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("start_addr", want.start_addr, got.start_addr);
          check_field("end_addr", want.end_addr, got.end_addr);
          check_field("au_size", want.au_size, got.au_size);
          check_field("used_count", want.used, got.used);
          check_field("free_count", want.free, got.free);
          check_field("cpb_write_addr", want.cpb_wr_addr, got.cpb_wr_addr);
          check_field("start_back_jump", want.start_jump, got.start_jump);
          check_field("end_back_jump", want.end_jump, got.end_jump);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_QUEUE_NODES: begin
            qnodes = cfg_data[QN_W-1:0];
            for (int c = 0; c < NUM_CHANNELS; c++) begin
              wr_idx[c] = 0;
              rd_idx[c] = 0;
            end
          end
          CFG_CPB_SIZE:  cpb = cfg_data;
          CFG_CH_ENABLE: ch_open = cfg_data[EN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(resolve_access(in_tuser[2:0], in_tuser[5:3],
                                                 in_tdata[31:0], in_tdata[63:32],
                                                 in_tdata[95:64], in_tdata[127:96]));
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== dv/tb.sv =====
// Top of the ring queue testbench: clock, reset, stimulus and the verdict.
// Instantiates multichannel_access_unit_ring_queue and mauq_checker; depends on mauq_pkg.
module tb;
  import mauq_pkg::*;

  localparam int HALF_PERIOD      = 6;
  localparam int RUN_LIMIT_CYCLES = 400000;
  // index 3 maps to no register; a write there must leave everything alone
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_USER_W-1:0]  in_tuser  = '0;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_USER_W-1:0] out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned miss_count;
  int unsigned awaited;

  // steady: no idling on either side while set
  bit          steady = 1'b0;
  // running address per channel number, so most pushes look like a real stream
  logic [31:0] next_addr [8];

  multichannel_access_unit_ring_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mauq_checker ring_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (miss_count),
    .outstanding(awaited)
  );

  always #HALF_PERIOD clk = ~clk;

  // result side: stall at random (probability 22/100) unless in a steady stretch
  always @(negedge clk) out_tready = steady || ($urandom_range(99) >= 22);

  // hard stop in case the block hangs
  initial begin
    #(2 * HALF_PERIOD * RUN_LIMIT_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] wide_word();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  // one access beat; inputs move on falling edges, the handshake is seen on rising ones
  task automatic send_access(input logic [ACT_W-1:0] act, input logic [CH_W-1:0] ch,
                             input logic [31:0] s_addr, input logic [31:0] e_addr,
                             input logic [31:0] au_sz, input logic [31:0] load_addr);
    if (!steady && $urandom_range(99) < 22) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tuser  = {ch, act};
    in_tdata  = {load_addr, au_sz, e_addr, s_addr};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold the sender until every result beat has been taken
  task automatic drain();
    in_tvalid = 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  // random access: mostly stream-like addresses, some backward steps, some raw noise
  task automatic random_access(input int push_pct, input int reset_pct, input int ch_hi);
    int             roll;
    logic [ACT_W-1:0] act;
    logic [CH_W-1:0]  ch;
    logic [31:0]    s_addr;
    logic [31:0]    e_addr;
    logic [31:0]    au_sz;
    logic [31:0]    load_addr;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      act = ACT_PUSH;
    end else if (roll < push_pct + reset_pct) begin
      act = ACT_RESET;
    end else begin
      roll = $urandom_range(99);
      if (roll < 55)      act = ACT_POP;
      else if (roll < 75) act = ACT_PEEK;
      else if (roll < 88) act = ACT_QUERY;
      else                act = ACT_W'($urandom_range(5, 7));  // spare codes act as query
    end
    if ($urandom_range(99) < 6) ch = CH_W'($urandom_range(NUM_CHANNELS, 7));
    else                        ch = CH_W'($urandom_range(ch_hi));
    roll = $urandom_range(99);
    if (roll < 15) begin
      s_addr = wide_word();
      e_addr = wide_word();
      au_sz  = wide_word();
    end else if (roll < 30) begin
      // short step back: flagged or not depending on the buffer size
      au_sz  = $urandom_range(1, 8192);
      s_addr = next_addr[ch] - $urandom_range(1, 3000);
      e_addr = s_addr + au_sz;
    end else if (roll < 33) begin
      // zero start: never counts as a previous address
      au_sz  = $urandom_range(0, 8192);
      s_addr = '0;
      e_addr = au_sz;
    end else begin
      au_sz  = $urandom_range(1, 8192);
      s_addr = next_addr[ch];
      e_addr = s_addr + au_sz;
    end
    load_addr = wide_word();
    next_addr[ch] = (act == ACT_RESET) ? load_addr : e_addr;
    send_access(act, ch, s_addr, e_addr, au_sz, load_addr);
  endtask

  // each phase reprograms the block while idle, then runs random accesses;
  // the midpoint drain keeps the sender waiting for all results at least once
  task automatic run_phase(input logic [QN_W-1:0] qn, input logic [31:0] cpb_bytes,
                           input logic [EN_W-1:0] enables, input int n, input int push_pct,
                           input int reset_pct, input int ch_hi, input bit calm);
    drain();
    write_reg(CFG_QUEUE_NODES, {{(CFG_DATA_W-QN_W){1'b0}}, qn});
    write_reg(CFG_CPB_SIZE, cpb_bytes);
    write_reg(CFG_CH_ENABLE, {{(CFG_DATA_W-EN_W){1'b0}}, enables});
    steady = calm;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain();
      random_access(push_pct, reset_pct, ch_hi);
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int c = 0; c < 8; c++) next_addr[c] = 32'h0000_1000 * (c + 1);
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: out-of-reset registers (all channels closed, capacity 256)
    send_access(ACT_QUERY, 3'd0, '0, '0, '0, '0);                   // closed
    send_access(ACT_PUSH,  3'd7, '1, '1, '1, '1);                   // bad channel, top
    send_access(ACT_QUERY, 3'd4, '0, '0, '0, '0);                   // first bad channel
    send_access(ACT_RESET, 3'd1, '0, '0, '0, 32'hFFFF_FFFF);        // reset on a closed channel
    send_access(ACT_POP,   3'd1, '0, '0, '0, '0);                   // closed, reports new addr

    // tiny rings (2 usable slots), buffer size 1000 -> jump threshold 800
    drain();
    write_reg(CFG_SPARE, $urandom);
    write_reg(CFG_CH_ENABLE, 32'h0000_000F);
    write_reg(CFG_CPB_SIZE, 32'd1000);
    write_reg(CFG_QUEUE_NODES, 32'd3);
    send_access(ACT_PEEK, 3'd0, '0, '0, '0, '0);                                 // empty
    send_access(ACT_PUSH, 3'd0, 32'd5000, 32'd6000, 32'hFFFF_FFFF, '0);
    send_access(ACT_PUSH, 3'd0, 32'd4201, 32'd5201, 32'd0, '0);                  // back 799
    send_access(ACT_PUSH, 3'd0, 32'd9000, 32'd9100, 32'd100, '0);                // full
    send_access(ACT_PEEK, 3'd0, '0, '0, '0, '0);
    send_access(ACT_POP,  3'd0, '0, '0, '0, '0);
    send_access(ACT_PUSH, 3'd0, 32'd3401, 32'd4401, 32'd1, '0);                  // back 800
    send_access(ACT_POP,  3'd0, '0, '0, '0, '0);                                 // pop back 799
    send_access(ACT_POP,  3'd0, '0, '0, '0, '0);                                 // pop back 800
    send_access(ACT_POP,  3'd0, '0, '0, '0, '0);                                 // empty
    send_access(ACT_QUERY, 3'd0, '0, '0, '0, '0);
    send_access(3'd5, 3'd2, '0, '0, '0, '0);
    send_access(3'd6, 3'd3, '0, '0, '0, '0);
    send_access(3'd7, 3'd0, '0, '0, '0, '0);
    send_access(ACT_PUSH, 3'd3, '1, '1, '1, '1);                                 // all ones
    send_access(ACT_PUSH, 3'd3, '0, '0, '0, '0);                                 // big drop
    send_access(ACT_PUSH, 3'd3, 32'd7, 32'd8, 32'd1, '0);                        // full
    send_access(ACT_RESET, 3'd3, '0, '0, '0, '0);
    send_access(ACT_QUERY, 3'd3, '0, '0, '0, '0);

    // random phases: capacity clamp extremes, buffer size extremes, enable masks
    run_phase(9'd2,   32'd0,          4'hF,                 80, 45, 4, 3, 1'b0);
    run_phase(9'd5,   32'd1000,       4'hF,                100, 50, 4, 3, 1'b1);
    // one deep ring: fill all 255 usable slots of channel 0 and hit full
    run_phase(9'd256, 32'hFFFF_FFFF,  4'h1,                300, 96, 0, 0, 1'b0);
    run_phase(9'd511, 32'h0001_0000,  4'hA,                100, 45, 3, 3, 1'b0);
    run_phase(9'd1,   $urandom,       4'h5,                 80, 50, 3, 3, 1'b0);
    run_phase(9'd17,  32'd1,          4'($urandom_range(15)), 100, 55, 3, 3, 1'b0);
    run_phase(9'd0,   32'd4000,       4'hF,                 90, 50, 5, 3, 1'b0);

    // wind down: all results in, then wait for stray beats
    drain();
    repeat (8) @(negedge clk);
    if (miss_count == 0 && awaited == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
